### hw/rtl/lbp_tile_histogram_assert.svh
// Assertion macros for the LBP tile histogram.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef LBP_TILE_HISTOGRAM_ASSERT_SVH
`define LBP_TILE_HISTOGRAM_ASSERT_SVH
`ifndef SYNTHESIS
`define LBP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lbp assertion failed");
`define LBP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lbp forbidden condition seen");
`else
`define LBP_ASSERT(lbl, clk, rst_n, prop)
`define LBP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### hw/rtl/lbp_pkg.sv
// Shared constants and types for the LBP tile histogram.
// No dependencies; imported by the interfaces and all modules.
package lbp_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned BIN_W       = 8;
  localparam int unsigned NUM_BINS    = 256;
  localparam int unsigned OUT_COUNT_W = 20;

  localparam int unsigned TILE_SIZE_DEF   = 20;
  localparam int unsigned COUNT_WIDTH_DEF = 20;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Pattern stage result, meaningful while that stage holds a pixel.
  typedef struct packed {
    logic [BIN_W-1:0] code;
    logic             border;
    logic             code_en;
  } pat_t;

endpackage

### hw/rtl/lbp_in_if.sv
// Input channel of the LBP tile histogram: valid/ready plus command payload.
// Depends on lbp_pkg.
interface lbp_in_if import lbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [PIXEL_W-1:0] pixel;
  logic [BIN_W-1:0]   bin_select;

  modport source (output valid, op, pixel, bin_select, input ready);
  modport sink   (input valid, op, pixel, bin_select, output ready);
endinterface

### hw/rtl/lbp_out_if.sv
// Output channel of the LBP tile histogram: valid/ready plus bin readout.
// Depends on lbp_pkg.
interface lbp_out_if import lbp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [BIN_W-1:0]       bin_number;
  logic [OUT_COUNT_W-1:0] bin_count;

  modport source (output valid, bin_number, bin_count, input ready);
  modport sink   (input valid, bin_number, bin_count, output ready);
endinterface

### hw/rtl/lbp_tile_histogram.sv
// LBP tile histogram top level: command pipeline, bin memory, readout.
// Depends on lbp_pkg, lbp_in_if, lbp_out_if, lbp_pattern and the assert header.
//
// Usage: in_i carries one command per beat. A push beat feeds the next pixel of
// the current tile (row-major, TILE_SIZE x TILE_SIZE); a read beat returns one
// beat on out_o with the bin number and its count (low 20 bits); a clear beat
// zeroes every bin and restarts the tile position. Other codes are dropped.
// Throughput is one beat per cycle for every command mix while no read result is
// held by a stalled out_o: each pixel costs at most one read-modify-write of the
// 256-entry bin memory, which has one read and one write port, and bin 0 lives in
// its own register so that a border pixel with a nonzero code still needs only
// that single memory access. Reads pass stage 1, stage 2 and the output register.
// Reset clears the tile position, the bin valid bits and bin 0 at once, so the
// block accepts beats from the first cycle after reset; no clearing pass.
// When out_o stalls with a result held, intake stops only once the next read
// reaches the last stage; pixels keep flowing until then.
`include "lbp_tile_histogram_assert.svh"
module lbp_tile_histogram import lbp_pkg::*; #(
  parameter int unsigned TILE_SIZE   = TILE_SIZE_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lbp_in_if.sink   in_i,
  lbp_out_if.source out_o
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  logic adv;
  logic push;
  logic clear;
  pat_t pat;

  logic            s1_v_q;
  logic [OP_W-1:0] s1_op_q;
  logic [BIN_W-1:0] s1_sel_q;

  logic             s2_v_q;
  logic [OP_W-1:0]  s2_op_q;
  logic [BIN_W-1:0] s2_bin_q;
  logic             s2_bump_q;
  logic [1:0]       s2_inc0_q;

  logic [COUNT_WIDTH-1:0] bin_mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] bin_rdata_q;
  logic [NUM_BINS-1:0]    valid_q;
  logic [COUNT_WIDTH-1:0] bin0_q, bin0_d;

  logic                   fwd_v_q;
  logic [BIN_W-1:0]       fwd_addr_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;

  logic                   out_v_q;
  logic [BIN_W-1:0]       out_bin_q;
  logic [OUT_COUNT_W-1:0] out_cnt_q;

  logic                   rd_en;
  logic [BIN_W-1:0]       rd_addr;
  logic                   s2_read;
  logic [COUNT_WIDTH-1:0] base;
  logic [COUNT_WIDTH-1:0] bump_val;
  logic                   bin_we;
  logic [COUNT_WIDTH:0]   bin0_sum;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic [OUT_COUNT_W+COUNT_WIDTH-1:0] rd_count_ext;

  assign s2_read = s2_v_q && (s2_op_q == OP_READ);
  assign adv     = !(s2_read && out_v_q && !out_o.ready);
  assign push    = adv && in_i.valid && (in_i.op == OP_PUSH);
  assign clear   = adv && in_i.valid && (in_i.op == OP_CLEAR);
  assign in_i.ready = adv;

  lbp_pattern #(
    .TILE_SIZE(TILE_SIZE)
  ) u_pattern (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .push_i  (push),
    .clear_i (clear),
    .pixel_i (in_i.pixel),
    .pat_o   (pat)
  );

  // Stage 1: issue the bin memory read.
  assign rd_en   = adv && s1_v_q;
  assign rd_addr = (s1_op_q == OP_PUSH) ? pat.code : s1_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_i.valid;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q   <= in_i.op;
      s1_sel_q  <= in_i.bin_select;
      s2_op_q   <= s1_op_q;
      s2_bin_q  <= rd_addr;
      s2_bump_q <= pat.code_en && (pat.code != '0);
      s2_inc0_q <= {1'b0, pat.border} + {1'b0, pat.code_en && (pat.code == '0)};
    end
  end

  // Stage 2: read-modify-write; the write of the previous advance is forwarded.
  always_comb begin
    if (fwd_v_q && (fwd_addr_q == s2_bin_q)) begin
      base = fwd_data_q;
    end else if (valid_q[s2_bin_q]) begin
      base = bin_rdata_q;
    end else begin
      base = '0;
    end
  end

  assign bump_val = (base == CountMax) ? base : base + COUNT_WIDTH'(1);
  assign bin_we   = adv && s2_v_q && (s2_op_q == OP_PUSH) && s2_bump_q;
  assign bin0_sum = {1'b0, bin0_q} + (COUNT_WIDTH + 1)'(s2_inc0_q);
  assign bin0_d   = (bin0_sum > {1'b0, CountMax}) ? CountMax : bin0_sum[COUNT_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    if (bin_we) begin
      bin_mem[s2_bin_q] <= bump_val;
    end
    if (rd_en) begin
      bin_rdata_q <= bin_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      bin0_q     <= '0;
      fwd_v_q    <= 1'b0;
      fwd_addr_q <= '0;
      fwd_data_q <= '0;
    end else if (adv) begin
      fwd_v_q    <= bin_we;
      fwd_addr_q <= s2_bin_q;
      fwd_data_q <= bump_val;
      if (s2_v_q) begin
        case (s2_op_q)
          OP_PUSH: begin
            bin0_q <= bin0_d;
            if (s2_bump_q) begin
              valid_q[s2_bin_q] <= 1'b1;
            end
          end
          OP_CLEAR: begin
            bin0_q  <= '0;
            valid_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Output register.
  assign rd_count     = (s2_bin_q == '0) ? bin0_q : base;
  assign rd_count_ext = (OUT_COUNT_W + COUNT_WIDTH)'(rd_count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv && s2_read) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_read) begin
      out_bin_q <= s2_bin_q;
      out_cnt_q <= rd_count_ext[OUT_COUNT_W-1:0];
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.bin_number = out_bin_q;
  assign out_o.bin_count  = out_cnt_q;

  `LBP_ASSERT(a_clear_empties, clk_i, rst_ni, (adv && s2_v_q && s2_op_q == OP_CLEAR) |=> (valid_q == '0))
  `LBP_ASSERT(a_out_from_read, clk_i, rst_ni, $rose(out_v_q) |-> $past(adv && s2_read))
  `LBP_ASSERT(a_bin0_no_wrap, clk_i, rst_ni, (adv && s2_v_q && s2_op_q == OP_PUSH) |=> (bin0_q >= $past(bin0_q)))

endmodule

### hw/rtl/lbp_pattern.sv
// Tile position, two-row line memory, 3x3 window and pattern code.
// Depends on lbp_pkg.
module lbp_pattern import lbp_pkg::*; #(
  parameter int unsigned TILE_SIZE = TILE_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               push_i,
  input  logic               clear_i,
  input  logic [PIXEL_W-1:0] pixel_i,
  output pat_t               pat_o
);

  localparam int unsigned PosW = $clog2(TILE_SIZE);
  localparam int unsigned LineW = 2 * PIXEL_W;

  logic [PosW-1:0] row_q, row_d;
  logic [PosW-1:0] col_q, col_d;

  // Each entry holds the same column of the two previous rows: {older, newer}.
  logic [LineW-1:0] line_mem [TILE_SIZE];
  logic [LineW-1:0] line_rdata_q;

  logic               s1_push_q;
  logic [PIXEL_W-1:0] s1_px_q;
  logic [PosW-1:0]    s1_col_q;
  logic               s1_border_q;
  logic               s1_code_en_q;

  // Two most recent columns per row; index 1 is the newer one.
  logic [PIXEL_W-1:0] win_q [3][2];

  logic               at_border;
  logic               code_en;
  logic [PIXEL_W-1:0] older;
  logic [PIXEL_W-1:0] newer;
  logic [PIXEL_W-1:0] ctr;
  logic [BIN_W-1:0]   code;

  assign at_border = (row_q == '0) || (row_q == PosW'(TILE_SIZE - 1)) ||
                     (col_q == '0) || (col_q == PosW'(TILE_SIZE - 1));
  assign code_en   = (row_q >= PosW'(2)) && (col_q >= PosW'(2));

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (clear_i) begin
      row_d = '0;
      col_d = '0;
    end else if (push_i) begin
      if (col_q == PosW'(TILE_SIZE - 1)) begin
        col_d = '0;
        row_d = (row_q == PosW'(TILE_SIZE - 1)) ? '0 : row_q + PosW'(1);
      end else begin
        col_d = col_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      s1_push_q <= 1'b0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      if (adv_i) begin
        s1_push_q <= push_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      s1_px_q      <= pixel_i;
      s1_col_q     <= col_q;
      s1_border_q  <= at_border;
      s1_code_en_q <= code_en;
    end
  end

  assign older = line_rdata_q[LineW-1:PIXEL_W];
  assign newer = line_rdata_q[PIXEL_W-1:0];
  assign ctr   = win_q[1][1];

  always_ff @(posedge clk_i) begin
    if (adv_i && s1_push_q) begin
      line_mem[s1_col_q] <= {newer, s1_px_q};
    end
    if (push_i) begin
      line_rdata_q <= line_mem[col_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= '0;
        win_q[k][1] <= '0;
      end
    end else if (adv_i && s1_push_q) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= win_q[k][1];
      end
      win_q[0][1] <= older;
      win_q[1][1] <= newer;
      win_q[2][1] <= s1_px_q;
    end
  end

  // Weights 128..1: above row, left, right, below row.
  assign code[7] = win_q[0][0] >= ctr;
  assign code[6] = win_q[0][1] >= ctr;
  assign code[5] = older       >= ctr;
  assign code[4] = win_q[1][0] >= ctr;
  assign code[3] = newer       >= ctr;
  assign code[2] = win_q[2][0] >= ctr;
  assign code[1] = win_q[2][1] >= ctr;
  assign code[0] = s1_px_q     >= ctr;

  assign pat_o.code    = code;
  assign pat_o.border  = s1_border_q;
  assign pat_o.code_en = s1_code_en_q;

endmodule

### verif/tb_lbp_tile_histogram.sv
// Self-checking testbench for lbp_tile_histogram: a directed table, then random
// pixel runs, reads, spare codes and clears, checked beat by beat against a local predictor.
// Depends on lbp_pkg, lbp_in_if, lbp_out_if and the RTL of the block.
module tb_lbp_tile_histogram;
  import lbp_pkg::*;

  localparam int unsigned TS          = TILE_SIZE_DEF;
  localparam int unsigned CW          = COUNT_WIDTH_DEF;
  localparam int unsigned N_ITEMS     = 1650;
  localparam int unsigned N_DIRECTED  = 16;
  localparam int unsigned DRAIN       = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic [31:0] CNT_MAX = 32'((64'd1 << CW) - 64'd1);

  typedef struct {
    logic [OP_W-1:0]        op;
    logic [PIXEL_W-1:0]     pixel;
    logic [BIN_W-1:0]       sel;
    int unsigned            reps;
    bit                     known;
    logic [OUT_COUNT_W-1:0] count;
  } stim_row_t;

  typedef struct {
    logic [BIN_W-1:0]       bin_number;
    logic [OUT_COUNT_W-1:0] bin_count;
  } readout_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  lbp_in_if  in_if ();
  lbp_out_if out_if ();

  lbp_tile_histogram #(
    .TILE_SIZE  (TS),
    .COUNT_WIDTH(CW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [PIXEL_W-1:0] prev_rows [2*TS];
  logic [PIXEL_W-1:0] win [3][3];
  int unsigned        row_pos;
  int unsigned        col_pos;
  logic [31:0]        hist [NUM_BINS];
  logic [BIN_W-1:0]   last_pattern;

  readout_t    read_expect_q [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left;
  rx_mode_e    rx_mode;
  int unsigned rx_left;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{OP_READ,  8'd0,   8'd0,   1, 1'b1, 20'd0},
    '{OP_READ,  8'd0,   8'd255, 1, 1'b1, 20'd0},
    '{OP_SPARE, 8'd255, 8'd0,   1, 1'b0, 20'd0},
    '{OP_READ,  8'd0,   8'd0,   1, 1'b1, 20'd0},
    '{OP_PUSH,  8'd0,   8'd255, 1, 1'b0, 20'd0},
    '{OP_PUSH,  8'd255, 8'd0,   1, 1'b0, 20'd0},
    '{OP_PUSH,  8'd128, 8'd0,   3, 1'b0, 20'd0},
    '{OP_READ,  8'd0,   8'd0,   1, 1'b1, 20'd5},
    '{OP_READ,  8'd255, 8'd255, 1, 1'b1, 20'd0},
    '{OP_CLEAR, 8'd255, 8'd255, 1, 1'b0, 20'd0},
    '{OP_READ,  8'd0,   8'd0,   1, 1'b1, 20'd0},
    '{OP_CLEAR, 8'd0,   8'd0,   1, 1'b0, 20'd0},
    '{OP_PUSH,  8'd255, 8'd0,   4, 1'b0, 20'd0},
    '{OP_READ,  8'd0,   8'd0,   1, 1'b0, 20'd0},
    '{OP_SPARE, 8'd0,   8'd255, 2, 1'b0, 20'd0},
    '{OP_READ,  8'd0,   8'd1,   1, 1'b0, 20'd0}
  };

  function automatic void hist_bump(logic [BIN_W-1:0] bin);
    if (hist[bin] < CNT_MAX) hist[bin] = hist[bin] + 32'd1;
  endfunction

  function automatic void histogram_apply(input logic [OP_W-1:0] op,
                                          input logic [PIXEL_W-1:0] px,
                                          input logic [BIN_W-1:0] sel,
                                          output bit has_result,
                                          output readout_t res);
    logic [PIXEL_W-1:0] older;
    logic [PIXEL_W-1:0] newer;
    logic [PIXEL_W-1:0] ctr;
    logic [BIN_W-1:0]   code;
    has_result = 1'b0;
    res = '{default: '0};
    case (op)
      OP_PUSH: begin
        older = prev_rows[col_pos];
        newer = prev_rows[TS + col_pos];
        prev_rows[col_pos] = newer;
        prev_rows[TS + col_pos] = px;
        for (int k = 0; k < 3; k++) begin
          win[k][0] = win[k][1];
          win[k][1] = win[k][2];
        end
        win[0][2] = older;
        win[1][2] = newer;
        win[2][2] = px;
        if (row_pos == 0 || row_pos == TS - 1 || col_pos == 0 || col_pos == TS - 1)
          hist_bump('0);
        if (row_pos >= 2 && col_pos >= 2) begin
          ctr  = win[1][1];
          code = {win[0][0] >= ctr, win[0][1] >= ctr, win[0][2] >= ctr,
                  win[1][0] >= ctr, win[1][2] >= ctr,
                  win[2][0] >= ctr, win[2][1] >= ctr, win[2][2] >= ctr};
          last_pattern = code;
          hist_bump(code);
        end
        col_pos++;
        if (col_pos >= TS) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= TS) row_pos = 0;
        end
      end
      OP_READ: begin
        has_result = 1'b1;
        res.bin_number = sel;
        res.bin_count = hist[sel][OUT_COUNT_W-1:0];
      end
      OP_CLEAR: begin
        foreach (hist[i]) hist[i] = '0;
        row_pos = 0;
        col_pos = 0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [PIXEL_W-1:0] px,
                           input logic [BIN_W-1:0] sel, input bit known,
                           input logic [OUT_COUNT_W-1:0] count);
    int unsigned gap;
    bit          has_result;
    readout_t    res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.pixel      <= px;
    in_if.bin_select <= sel;
    do @(posedge clk_i); while (!in_if.ready);
    histogram_apply(op, px, sel, has_result, res);
    if (has_result) begin
      if (known) res.bin_count = count;
      read_expect_q.push_back(res);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    readout_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (read_expect_q.size() == 0) begin
        $error("bin_number: unexpected beat, expected none, got %0d", out_if.bin_number);
        mismatch_count++;
      end else begin
        exp_res = read_expect_q.pop_front();
        if (out_if.bin_number !== exp_res.bin_number) begin
          $error("bin_number: expected %0d, got %0d", exp_res.bin_number,
                 out_if.bin_number);
          mismatch_count++;
        end
        if (out_if.bin_count !== exp_res.bin_count) begin
          $error("bin_count: expected %0d, got %0d", exp_res.bin_count,
                 out_if.bin_count);
          mismatch_count++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_mode      <= RX_OPEN;
      rx_left      <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_left <= $urandom_range(16, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_if.ready <= ($urandom_range(0, 5) == 0);
        RX_TOGGLE: out_if.ready <= ~out_if.ready;
        default:   out_if.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned        n_items;
    int unsigned        kind;
    int unsigned        run_len;
    int unsigned        mode;
    logic [PIXEL_W-1:0] base;
    logic [PIXEL_W-1:0] step;
    logic [PIXEL_W-1:0] px;
    logic [BIN_W-1:0]   sel;

    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.op         = OP_PUSH;
    in_if.pixel      = '0;
    in_if.bin_select = '0;
    burst_left       = 0;
    row_pos          = 0;
    col_pos          = 0;
    last_pattern     = '0;
    foreach (prev_rows[i]) prev_rows[i] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    foreach (hist[i]) hist[i] = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    n_items = 0;
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_beat(directed_rows[r].op, directed_rows[r].pixel, directed_rows[r].sel,
                  directed_rows[r].known, directed_rows[r].count);
        if (directed_rows[r].op != OP_SPARE) n_items++;
      end
    end

    while (n_items < N_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // pixel run: random, near-flat (many ties), constant, or ramp
        run_len = $urandom_range(1, 60);
        mode    = $urandom_range(0, 3);
        base    = 8'($urandom_range(0, 255));
        step    = 8'($urandom_range(1, 9));
        for (int i = 0; i < run_len; i++) begin
          case (mode)
            0:       px = 8'($urandom_range(0, 255));
            1:       px = base + 8'($urandom_range(0, 2));
            2:       px = base;
            default: px = base + 8'(i) * step;
          endcase
          send_beat(OP_PUSH, px, 8'($urandom_range(0, 255)), 1'b0, '0);
          n_items++;
        end
      end else if (kind < 95) begin
        run_len = $urandom_range(1, 3);
        for (int i = 0; i < run_len; i++) begin
          case ($urandom_range(0, 3))
            0:       sel = '0;
            1:       sel = last_pattern;
            2:       sel = 8'($urandom_range(0, 255));
            default: sel = 8'hFF;
          endcase
          send_beat(OP_READ, 8'($urandom_range(0, 255)), sel, 1'b0, '0);
          n_items++;
        end
      end else if (kind < 98) begin
        send_beat(OP_SPARE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'b0, '0);
      end else begin
        send_beat(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'b0, '0);
        n_items++;
      end
    end
    in_if.valid <= 1'b0;

    while (read_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/lbp_pkg.sv
hw/rtl/lbp_in_if.sv
hw/rtl/lbp_out_if.sv
hw/rtl/lbp_pattern.sv
hw/rtl/lbp_tile_histogram.sv
verif/tb_lbp_tile_histogram.sv
